FILE: design/scba_pkg.sv
// Shared constants for the size-class bitmap allocator.
// Depends on nothing; imported by every module of the block.
package scba_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_TOO_LARGE    = 3'd1,
      STATUS_NO_FREE      = 3'd2,
      STATUS_OUTSIDE      = 3'd3,
      STATUS_ALREADY_FREE = 3'd4
   } status_type;

   // operation codes carried in req_tuser
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   // configuration register indexes
   localparam logic CSR_POOL_BASE      = 1'b0;
   localparam logic CSR_REGIONS_IN_USE = 1'b1;

   // log2 of the smallest block (32 bytes)
   localparam int MIN_BLOCK_SHIFT = 5;
   // bits per bitmap word
   localparam int MAP_WORD_BITS   = 64;
   localparam int MAP_BIT_W       = 6;

endpackage

FILE: design/size_class_bitmap_allocator_core.sv
// Size-class bitmap allocator core: sequencer, config registers, result register.
// Depends on scba_pkg, scba_bitmap_ram and scba_ffz.
//
// Allocates and releases fixed-size blocks out of CLASS_COUNT*GROUP_COUNT equal
// regions of REGION_KB KiB laid out back to back from pool_base; region n holds
// blocks of 32 << (n mod CLASS_COUNT) bytes. After reset the block clears its
// bitmap memory, one 64-bit word per cycle (REGION_COUNT*MAX_WORDS words, 320 at
// the defaults), with req_tready low; csr writes are taken throughout. One word is
// handled at a time. A release probes regions class by class and group by group,
// up to and including the one holding the address (1..40 regions), then reads its
// bitmap word, unless the address lands in a region's tail. An allocation skips or
// probes regions from the smallest class that fits, reading their bitmap words one
// at a time through the single read port. A new request is taken while the
// previous result waits on rsp_tready.
module size_class_bitmap_allocator_core
   import scba_pkg::*;
#(
   parameter int REGION_KB   = 16,
   parameter int GROUP_COUNT = 4,
   parameter int CLASS_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request word
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] request_bytes, [47:16] block_address
   input  logic        req_tuser,   // [0] op
   // result word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] granted_address, [34:32] status, rest zero
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int REGION_COUNT = GROUP_COUNT * CLASS_COUNT;
   localparam int REGION_BYTES = REGION_KB * 1024;
   localparam int BLOCKS_MAX   = REGION_KB * 32;
   localparam int MAX_WORDS    = (BLOCKS_MAX + 63) / 64;
   localparam int DEPTH        = REGION_COUNT * MAX_WORDS;
   localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CLS_W        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int GRP_W        = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int REG_W        = $clog2(REGION_COUNT + 1);
   localparam int WRD_W        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int BIDX_W       = WRD_W + MAP_BIT_W;
   localparam int NB_W         = $clog2(BLOCKS_MAX + 1);
   localparam int CNT_W        = (REG_W > 6) ? REG_W : 6;
   localparam int SH_W         = 5;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_SEL, ST_A_REG, ST_A_CHK,
      ST_R_REG, ST_R_CHK, ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic [31:0]               pool_base_ff, pool_base_in;
   logic [5:0]                regions_ff, regions_in;
   logic                      op_ff, op_in;
   logic [15:0]               bytes_ff, bytes_in;
   logic [31:0]               baddr_ff, baddr_in;
   logic [CLS_W-1:0]          cls_ff, cls_in;
   logic [GRP_W-1:0]          grp_ff, grp_in;
   logic [REG_W-1:0]          n_ff, n_in;
   logic [31:0]               start_ff, start_in;
   logic [WRD_W-1:0]          w_ff, w_in;
   logic [MAP_BIT_W-1:0]      bit_ff, bit_in;
   logic [31:0]               res_addr_ff, res_addr_in;
   status_type                res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_addr_ff, rsp_addr_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic                      wr_en, rd_en;
   logic [ADDR_W-1:0]         wr_addr, rd_addr, cur_addr;
   logic [MAP_WORD_BITS-1:0]  wr_data, rd_data, cand;
   logic                      ffz_found;
   logic [MAP_BIT_W-1:0]      ffz_index;

   logic [SH_W-1:0]           shift;
   logic [NB_W-1:0]           nblocks;
   logic [NB_W:0]             nwords;
   logic                      active;
   logic [CLS_W-1:0]          first_cls;
   logic                      too_large;
   logic [31:0]               offset, blk;
   logic                      last_grp, last_cls, more_words;

   scba_bitmap_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   scba_ffz u_ffz (
      .map_word(cand),
      .found   (ffz_found),
      .index   (ffz_index)
   );

   // per-class geometry
   assign shift   = SH_W'(MIN_BLOCK_SHIFT) + SH_W'(cls_ff);
   assign nblocks = NB_W'(BLOCKS_MAX) >> cls_ff;
   assign nwords  = ((NB_W + 1)'(nblocks) + (NB_W + 1)'(63)) >> MAP_BIT_W;
   assign active  = CNT_W'(n_ff) < CNT_W'(regions_ff);
   assign cur_addr = ADDR_W'(n_ff) * ADDR_W'(MAX_WORDS) + ADDR_W'(w_ff);
   assign last_grp = (32'(grp_ff) == 32'(GROUP_COUNT - 1));
   assign last_cls = (32'(cls_ff) == 32'(CLASS_COUNT - 1));
   assign more_words = ((NB_W + 1)'(w_ff) + (NB_W + 1)'(1)) < nwords;

   // release: offset of the address in the current region
   assign offset = baddr_ff - start_ff;
   assign blk    = offset >> shift;

   // bits past the last block of the region read as taken
   always_comb begin
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         cand[i] = rd_data[i] |
                   (32'({w_ff, MAP_BIT_W'(i)}) >= 32'(nblocks));
      end
   end

   // smallest class that holds the request
   always_comb begin
      first_cls = '0;
      too_large = 32'(bytes_ff) > (32'(1) << (MIN_BLOCK_SHIFT + CLASS_COUNT - 1));
      for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
         if ((32'(1) << (MIN_BLOCK_SHIFT + c)) >= 32'(bytes_ff)) begin
            first_cls = CLS_W'(c);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pool_base_in  = pool_base_ff;
      regions_in    = regions_ff;
      op_in         = op_ff;
      bytes_in      = bytes_ff;
      baddr_in      = baddr_ff;
      cls_in        = cls_ff;
      grp_in        = grp_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      w_in          = w_ff;
      bit_in        = bit_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = cur_addr;

      if (csr_we) begin
         case (csr_index)
            CSR_POOL_BASE:      pool_base_in = csr_wdata;
            CSR_REGIONS_IN_USE: regions_in   = csr_wdata[5:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (32'(clr_ff) == 32'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               bytes_in = req_tdata[15:0];
               baddr_in = req_tdata[47:16];
               state_in = ST_START;
            end
         end
         ST_START: begin
            grp_in   = '0;
            res_addr_in = '0;
            if (op_ff == OP_RELEASE) begin
               cls_in   = '0;
               state_in = ST_SEL;
            end else if (too_large) begin
               res_status_in = STATUS_TOO_LARGE;
               state_in      = ST_DONE;
            end else begin
               cls_in   = first_cls;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            n_in     = REG_W'(32'(grp_ff) * CLASS_COUNT + 32'(cls_ff));
            start_in = pool_base_ff +
                       32'(32'(grp_ff) * CLASS_COUNT + 32'(cls_ff)) * 32'(REGION_BYTES);
            w_in     = '0;
            state_in = (op_ff == OP_RELEASE) ? ST_R_REG : ST_A_REG;
         end
         ST_A_REG: begin
            if (active && nwords != '0) begin
               rd_en    = 1'b1;
               state_in = ST_A_CHK;
            end else if (!last_grp) begin
               grp_in   = grp_ff + GRP_W'(1);
               state_in = ST_SEL;
            end else if (!last_cls) begin
               grp_in   = '0;
               cls_in   = cls_ff + CLS_W'(1);
               state_in = ST_SEL;
            end else begin
               res_status_in = STATUS_NO_FREE;
               state_in      = ST_DONE;
            end
         end
         ST_A_CHK: begin
            if (ffz_found) begin
               wr_en   = 1'b1;
               wr_data = rd_data | (MAP_WORD_BITS'(1) << ffz_index);
               res_addr_in   = start_ff + (32'({w_ff, ffz_index}) << shift);
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end else if (more_words) begin
               w_in    = w_ff + WRD_W'(1);
               rd_en   = 1'b1;
               rd_addr = cur_addr + ADDR_W'(1);
            end else if (!last_grp) begin
               grp_in   = grp_ff + GRP_W'(1);
               state_in = ST_SEL;
            end else if (!last_cls) begin
               grp_in   = '0;
               cls_in   = cls_ff + CLS_W'(1);
               state_in = ST_SEL;
            end else begin
               res_status_in = STATUS_NO_FREE;
               state_in      = ST_DONE;
            end
         end
         ST_R_REG: begin
            if (active && offset < 32'(REGION_BYTES)) begin
               if (blk >= 32'(nblocks)) begin
                  res_status_in = STATUS_OUTSIDE;
                  state_in      = ST_DONE;
               end else begin
                  w_in     = blk[BIDX_W-1:MAP_BIT_W];
                  bit_in   = blk[MAP_BIT_W-1:0];
                  state_in = ST_R_CHK;
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(n_ff) * ADDR_W'(MAX_WORDS) +
                             ADDR_W'(blk[BIDX_W-1:MAP_BIT_W]);
               end
            end else if (!last_grp) begin
               grp_in   = grp_ff + GRP_W'(1);
               state_in = ST_SEL;
            end else if (!last_cls) begin
               grp_in   = '0;
               cls_in   = cls_ff + CLS_W'(1);
               state_in = ST_SEL;
            end else begin
               res_status_in = STATUS_OUTSIDE;
               state_in      = ST_DONE;
            end
         end
         ST_R_CHK: begin
            if (!rd_data[bit_ff]) begin
               res_status_in = STATUS_ALREADY_FREE;
            end else begin
               wr_en   = 1'b1;
               wr_data = rd_data & ~(MAP_WORD_BITS'(1) << bit_ff);
               res_status_in = STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pool_base_ff <= '0;
         regions_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pool_base_ff <= pool_base_in;
         regions_ff   <= regions_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      bytes_ff      <= bytes_in;
      baddr_ff      <= baddr_in;
      cls_ff        <= cls_in;
      grp_ff        <= grp_in;
      n_ff          <= n_in;
      start_ff      <= start_in;
      w_ff          <= w_in;
      bit_ff        <= bit_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_addr_ff};

endmodule

FILE: design/scba_bitmap_ram.sv
// Occupancy bitmap memory: one write port, one read port, registered read.
// Depends on scba_pkg for the word width.
module scba_bitmap_ram
   import scba_pkg::*;
#(
   parameter int DEPTH  = 320,
   parameter int ADDR_W = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [MAP_WORD_BITS-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [MAP_WORD_BITS-1:0] rd_data
);

   logic [MAP_WORD_BITS-1:0] mem [DEPTH];
   logic [MAP_WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scba_ffz.sv
// Find-first-zero over one bitmap word, lowest bit first.
// Depends on scba_pkg for the word width.
module scba_ffz
   import scba_pkg::*;
(
   input  logic [MAP_WORD_BITS-1:0] map_word,
   output logic                     found,
   output logic [MAP_BIT_W-1:0]     index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!map_word[i]) begin
            found = 1'b1;
            index = MAP_BIT_W'(i);
         end
      end
   end

endmodule

FILE: tb/size_class_bitmap_allocator_checker.sv
// Checker for the size-class bitmap allocator: watches both streams, predicts
// each result from its own allocator state and compares. Depends on scba_pkg.
`timescale 1ns / 100ps
module size_class_bitmap_allocator_checker
   import scba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   localparam int REGION_BYTES = 16 * 1024;
   localparam int NCLASS = 10;
   localparam int NGROUP = 4;
   localparam int NREGION = NCLASS * NGROUP;
   localparam int NBLK = REGION_BYTES / 32;

   typedef struct packed {
      logic [31:0] addr;
      status_type  status;
   } grant_t;

   bit          used_map [NREGION][NBLK];
   logic [31:0] base_addr;
   logic [5:0]  live_regions;
   grant_t      grant_q[$];

   function automatic int blocks_in(int c);
      return REGION_BYTES / (32 << c);
   endfunction

   function automatic int active_n();
      return (live_regions > NREGION) ? NREGION : live_regions;
   endfunction

   function automatic grant_t allocate(logic [15:0] bytes);
      grant_t r;
      int c0, n;
      r.addr = '0;
      r.status = STATUS_NO_FREE;
      if (bytes > 16384) begin
         r.status = STATUS_TOO_LARGE;
         return r;
      end
      c0 = 0;
      while ((32 << c0) < bytes) c0++;
      for (int c = c0; c < NCLASS; c++) begin
         for (int g = 0; g < NGROUP; g++) begin
            n = g * NCLASS + c;
            if (n >= active_n()) continue;
            for (int b = 0; b < blocks_in(c); b++) begin
               if (!used_map[n][b]) begin
                  used_map[n][b] = 1;
                  r.addr = base_addr + n * REGION_BYTES + b * (32 << c);
                  r.status = STATUS_OK;
                  return r;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic grant_t release_block(logic [31:0] a);
      grant_t r;
      int n, b;
      logic [31:0] off;
      r.addr = '0;
      r.status = STATUS_OUTSIDE;
      for (int c = 0; c < NCLASS; c++) begin
         for (int g = 0; g < NGROUP; g++) begin
            n = g * NCLASS + c;
            if (n >= active_n()) continue;
            off = a - (base_addr + n * REGION_BYTES);
            if (off >= REGION_BYTES) continue;
            b = off / (32 << c);
            if (b >= blocks_in(c)) begin
               r.status = STATUS_OUTSIDE;
            end else if (!used_map[n][b]) begin
               r.status = STATUS_ALREADY_FREE;
            end else begin
               used_map[n][b] = 0;
               r.status = STATUS_OK;
            end
            return r;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      grant_t e;
      if (reset) begin
         foreach (used_map[i, j]) used_map[i][j] = 0;
         base_addr = '0;
         live_regions = '0;
         grant_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_POOL_BASE) base_addr = csr_wdata;
            else live_regions = csr_wdata[5:0];
         end
         // the result is checked first: a word taken this edge cannot answer yet
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               fail_count++;
            end else begin
               e = grant_q.pop_front();
               if (rsp_tdata[31:0] !== e.addr) begin
                  $error("granted_address expected %h got %h", e.addr, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[34:32] !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_tdata[34:32]);
                  fail_count++;
               end
               if (rsp_tdata[39:35] !== '0) begin
                  $error("pad expected 0 got %h", rsp_tdata[39:35]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            grant_q.push_back(req_tuser == OP_ALLOCATE ? allocate(req_tdata[15:0])
                                                        : release_block(req_tdata[47:16]));
      end
      pending = grant_q.size();
   end
endmodule

FILE: tb/size_class_bitmap_allocator_core_tb.sv
// Testbench top for size_class_bitmap_allocator_core: clock, reset, stimulus
// and verdict. Depends on scba_pkg, the core and the checker module.
`timescale 1ns / 100ps
module size_class_bitmap_allocator_core_tb;
   import scba_pkg::*;

   localparam int REGION_BYTES = 16 * 1024;
   localparam int STALL_LIMIT = 20000;  // idle cycles before the watchdog fires

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = OP_ALLOCATE;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 0;
   logic        csr_index = CSR_POOL_BASE;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending;

   bit          hold_off = 0;   // long receiver stall requested
   bit          calm = 0;       // no random idling on either side
   int          quiet_cycles = 0;
   logic [31:0] cur_base = 0;
   logic [31:0] taken_q[$];     // granted addresses, for releases

   always #5 clock = ~clock;

   size_class_bitmap_allocator_core u_dut (.*);

   size_class_bitmap_allocator_checker u_chk (.*);

   // keep a pool of live blocks so releases mostly hit real allocations
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[34:32] == STATUS_OK
          && rsp_tdata[31:0] != 0 && taken_q.size() < 400)
         taken_q.push_back(rsp_tdata[31:0]);

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off) rsp_tready <= 0;
      else rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off)
         quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_POOL_BASE) cur_base = val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // one word onto the request stream; valid stays up between back-to-back words
   task automatic send_word(input logic op, input logic [15:0] bytes,
                            input logic [31:0] addr);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {addr, bytes};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_word();
      int pick;
      logic [31:0] a;
      pick = $urandom_range(99);
      if (pick < 50) begin
         // mostly small sizes, sometimes anything
         if ($urandom_range(9) < 8) send_word(OP_ALLOCATE, 16'(32 << $urandom_range(9)
                                               >> $urandom_range(1)), '0);
         else send_word(OP_ALLOCATE, 16'($urandom), '0);
      end else if (pick < 85 && taken_q.size() > 0) begin
         a = taken_q[$urandom_range(taken_q.size() - 1)];
         if ($urandom_range(3) == 0) a = a + $urandom_range(31);
         else if ($urandom_range(3) == 0) taken_q.delete(0);
         send_word(OP_RELEASE, 16'($urandom), a);
      end else if (pick < 93) begin
         send_word(OP_RELEASE, 16'($urandom),
                   cur_base + $urandom_range(40 * REGION_BYTES + 4096));
      end else begin
         send_word(OP_RELEASE, 16'($urandom), $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty pool, then the full pool of 40 regions
      send_word(OP_ALLOCATE, 16'd0, '0);
      drain();
      csr_write(CSR_REGIONS_IN_USE, 32'd40);
      send_word(OP_ALLOCATE, 16'd0, 32'hFFFF_FFFF);   // zero-byte request
      send_word(OP_ALLOCATE, 16'd32, '0);
      send_word(OP_ALLOCATE, 16'd33, '0);
      send_word(OP_ALLOCATE, 16'd16384, '0);
      send_word(OP_ALLOCATE, 16'd16385, '0);           // too large
      send_word(OP_ALLOCATE, 16'hFFFF, '0);
      send_word(OP_ALLOCATE, 16'd16384, '0);
      send_word(OP_ALLOCATE, 16'd16384, '0);
      send_word(OP_ALLOCATE, 16'd16384, '0);
      send_word(OP_ALLOCATE, 16'd16384, '0);           // class exhausted
      send_word(OP_RELEASE, 16'hFFFF, 32'd9 * REGION_BYTES + 5);  // unaligned
      send_word(OP_RELEASE, '0, 32'd9 * REGION_BYTES);  // double release
      send_word(OP_RELEASE, '0, 32'd40 * REGION_BYTES); // outside
      send_word(OP_RELEASE, '0, 32'hFFFF_FFFF);
      send_word(OP_RELEASE, '0, 32'd32);
      drain();
      csr_write(CSR_REGIONS_IN_USE, 32'd63);           // clamps to 40
      csr_write(CSR_POOL_BASE, 32'hFFFF_8000);          // wraps
      send_word(OP_ALLOCATE, 16'd100, '0);
      send_word(OP_RELEASE, '0, 32'hFFFF_8000 + 32'd2 * REGION_BYTES);
      send_word(OP_RELEASE, '0, 32'hFFFF_FFFF);
      drain();
      taken_q.delete();

      // random phases with different settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin csr_write(CSR_POOL_BASE, 32'h0001_0000);
                     csr_write(CSR_REGIONS_IN_USE, 32'd40); end
            1: begin csr_write(CSR_REGIONS_IN_USE, 32'd3); end
            2: begin csr_write(CSR_POOL_BASE, $urandom & 32'hFFFF_FFE0);
                     csr_write(CSR_REGIONS_IN_USE, 32'd25); end
            3: begin csr_write(CSR_POOL_BASE, 32'h0);
                     csr_write(CSR_REGIONS_IN_USE, 32'd0); end
            default: begin csr_write(CSR_POOL_BASE, 32'hFFFF_FFFF);
                     csr_write(CSR_REGIONS_IN_USE, 32'd40); end
         endcase
         taken_q.delete();
         for (int i = 0; i < (ph == 3 ? 50 : 270); i++) begin
            calm = (ph == 0 && i >= 100 && i < 180);
            if (ph == 2 && i == 50) begin
               // long receiver hold-off while requests keep coming
               fork
                  begin
                     hold_off = 1;
                     for (int k = 0; k < 300; k++) @(negedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            random_word();
         end
         calm = 0;
         drain();
      end

      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
